[src/pda_pkg.sv]
// Shared types, widths and the sequencer program of the proper divisor analyzer.
package pda_pkg;

	localparam int NUMBER_W     = 32;
	localparam int OPER_W       = 32;
	localparam int TRIAL_W      = 17;
	localparam int SQ_W         = 33;
	localparam int COUNT_W      = 11;
	localparam int SUM_W        = 36;
	localparam int STEP_W       = 4;
	localparam int NUM_BITS_DEF = 32;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_INIT,
		ACT_DIV_GO,
		ACT_ACCUM,
		ACT_FINISH,
		ACT_FIRST,
		ACT_CHECK,
		ACT_EMIT
	} act_t;

	typedef enum logic [1:0] {
		HOLD_NEVER,
		HOLD_NO_INPUT,
		HOLD_DIV_BUSY,
		HOLD_OUT_FULL
	} hold_t;

	typedef enum logic [2:0] {
		JMP_NEVER,
		JMP_ALWAYS,
		JMP_SQ_ABOVE,
		JMP_SECOND_PASS,
		JMP_PARTNER
	} jmp_t;

	localparam logic [STEP_W-1:0] STEP_WAIT     = 4'd0;
	localparam logic [STEP_W-1:0] STEP_INIT     = 4'd1;
	localparam logic [STEP_W-1:0] STEP_TEST     = 4'd2;
	localparam logic [STEP_W-1:0] STEP_DIV_GO   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_DIV_WAIT = 4'd4;
	localparam logic [STEP_W-1:0] STEP_ACCUM    = 4'd5;
	localparam logic [STEP_W-1:0] STEP_FINISH   = 4'd6;
	localparam logic [STEP_W-1:0] STEP_FIRST    = 4'd7;
	localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd8;
	localparam logic [STEP_W-1:0] STEP_CHECK    = 4'd10;

	typedef struct packed {
		hold_t             hold;
		act_t              act;
		jmp_t              jmp;
		logic [STEP_W-1:0] target;
	} uword_t;

	// Control store: one word per step.
	function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
		uword_t w;
		w = '{hold: HOLD_NEVER, act: ACT_NONE, jmp: JMP_ALWAYS, target: STEP_WAIT};
		case (step)
			STEP_WAIT:     w = '{hold: HOLD_NO_INPUT, act: ACT_LOAD, jmp: JMP_NEVER,
			                     target: STEP_WAIT};
			STEP_INIT:     w = '{hold: HOLD_NEVER, act: ACT_INIT, jmp: JMP_NEVER,
			                     target: STEP_WAIT};
			STEP_TEST:     w = '{hold: HOLD_NEVER, act: ACT_NONE, jmp: JMP_SQ_ABOVE,
			                     target: STEP_FINISH};
			STEP_DIV_GO:   w = '{hold: HOLD_NEVER, act: ACT_DIV_GO, jmp: JMP_NEVER,
			                     target: STEP_WAIT};
			STEP_DIV_WAIT: w = '{hold: HOLD_DIV_BUSY, act: ACT_NONE, jmp: JMP_NEVER,
			                     target: STEP_WAIT};
			STEP_ACCUM:    w = '{hold: HOLD_NEVER, act: ACT_ACCUM, jmp: JMP_ALWAYS,
			                     target: STEP_TEST};
			STEP_FINISH:   w = '{hold: HOLD_NEVER, act: ACT_FINISH, jmp: JMP_SECOND_PASS,
			                     target: STEP_CHECK};
			STEP_FIRST:    w = '{hold: HOLD_NEVER, act: ACT_FIRST, jmp: JMP_PARTNER,
			                     target: STEP_INIT};
			STEP_EMIT:     w = '{hold: HOLD_OUT_FULL, act: ACT_EMIT, jmp: JMP_ALWAYS,
			                     target: STEP_WAIT};
			STEP_CHECK:    w = '{hold: HOLD_NEVER, act: ACT_CHECK, jmp: JMP_ALWAYS,
			                     target: STEP_EMIT};
			default:       w = '{hold: HOLD_NEVER, act: ACT_NONE, jmp: JMP_ALWAYS,
			                     target: STEP_WAIT};
		endcase
		return w;
	endfunction

endpackage

[src/pda_div.sv]
// Restoring divider, one quotient bit per cycle.
module pda_div #(
	parameter int DIVIDEND_W = pda_pkg::OPER_W,
	parameter int DIVISOR_W  = pda_pkg::TRIAL_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  busy,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic [DIVISOR_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [CNT_W-1:0]      bits_q;
	logic [DIVISOR_W:0]    partial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	assign partial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff    = partial - {1'b0, dvs_q};
	assign fits    = partial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
		end else if (start) begin
			bits_q <= CNT_W'(DIVIDEND_W);
		end else if (bits_q != '0) begin
			bits_q <= bits_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (bits_q != '0) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
		end
	end

	assign busy      = bits_q != '0;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[src/proper_divisor_analyzer.sv]
// Top level: microcoded trial-division analyzer of proper divisors.
//
//   channel         signals                                   direction
//   number          num_valid, num_ready, number              in
//   result          res_valid, res_ready, divisor_count,      out
//                   divisor_sum, is_perfect, is_amicable_smaller
//   partner limit   partner_limit_we, partner_limit_wdata     in (write only)
//
// A pass over operand m runs test, divider start, divider iterations, wait exit and
// accumulate for each candidate up to floor(sqrt(m)); the shared bit-serial divider
// dominates that cost. A second pass over the divisor sum runs only for a candidate
// partner.
// Reset clears the step counter, pass marker and result valid and sets the partner limit to all ones.
// A stalled result holds while the next number runs; only the emit step waits on it.
module proper_divisor_analyzer #(
	parameter int NUM_BITS = pda_pkg::NUM_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         num_valid,
	output logic                         num_ready,
	input  logic [pda_pkg::NUMBER_W-1:0] number,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [pda_pkg::COUNT_W-1:0]  divisor_count,
	output logic [pda_pkg::SUM_W-1:0]    divisor_sum,
	output logic                         is_perfect,
	output logic                         is_amicable_smaller,
	input  logic                         partner_limit_we,
	input  logic [pda_pkg::NUMBER_W-1:0] partner_limit_wdata
);

	localparam int KEEP_W = (NUM_BITS < pda_pkg::NUMBER_W) ? NUM_BITS : pda_pkg::NUMBER_W;
	localparam logic [pda_pkg::NUMBER_W-1:0] IN_MASK =
		pda_pkg::NUMBER_W'((64'd1 << KEEP_W) - 64'd1);

	localparam int SW = pda_pkg::SUM_W;
	localparam int CW = pda_pkg::COUNT_W;
	localparam int TW = pda_pkg::TRIAL_W;
	localparam int QW = pda_pkg::SQ_W;
	localparam int OW = pda_pkg::OPER_W;

	// Sequencer
	logic [pda_pkg::STEP_W-1:0] step_q;
	pda_pkg::uword_t            uw;
	logic                       held;
	logic                       taken;
	logic                       go;

	// Datapath
	logic [pda_pkg::NUMBER_W-1:0] n_q;
	logic [OW-1:0]                oper_q;
	logic [TW-1:0]                trial_q;
	logic [QW-1:0]                sq_q;
	logic [CW-1:0]                cnt_q;
	logic [SW-1:0]                sum_q;
	logic [CW-1:0]                fp_cnt_q;
	logic [SW-1:0]                fp_sum_q;
	logic                         perfect_q;
	logic                         amic_q;
	logic                         second_q;
	logic [pda_pkg::NUMBER_W-1:0] limit_q;
	logic                         partner;
	logic                         res_full;

	// Divider
	logic          div_start;
	logic          div_busy;
	logic [OW-1:0] div_quo;
	logic [TW-1:0] div_rem;

	assign uw = pda_pkg::ucode_rom(step_q);

	assign res_full = res_valid && !res_ready;

	// Stall the current step until its wait condition clears.
	always_comb begin
		case (uw.hold)
			pda_pkg::HOLD_NEVER:    held = 1'b0;
			pda_pkg::HOLD_NO_INPUT: held = !num_valid;
			pda_pkg::HOLD_DIV_BUSY: held = div_busy;
			pda_pkg::HOLD_OUT_FULL: held = res_full;
			default:                held = 1'b0;
		endcase
	end

	assign go = !held;

	// A partner is worth a second pass when it is above the number and within the limit.
	assign partner = (n_q != '0) && (sum_q > SW'(n_q)) && (sum_q <= SW'(limit_q));

	always_comb begin
		case (uw.jmp)
			pda_pkg::JMP_NEVER:       taken = 1'b0;
			pda_pkg::JMP_ALWAYS:      taken = 1'b1;
			pda_pkg::JMP_SQ_ABOVE:    taken = sq_q > QW'(oper_q);
			pda_pkg::JMP_SECOND_PASS: taken = second_q;
			pda_pkg::JMP_PARTNER:     taken = partner;
			default:                  taken = 1'b0;
		endcase
	end

	assign num_ready = (uw.act == pda_pkg::ACT_LOAD);
	assign div_start = (uw.act == pda_pkg::ACT_DIV_GO);

	pda_div #(
		.DIVIDEND_W(OW),
		.DIVISOR_W (TW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (oper_q),
		.divisor  (trial_q),
		.busy     (div_busy),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// Control registers: step counter, pass marker, result valid, limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= pda_pkg::STEP_WAIT;
			second_q  <= 1'b0;
			res_valid <= 1'b0;
			limit_q   <= '1;
		end else begin
			if (partner_limit_we) begin
				limit_q <= partner_limit_wdata;
			end
			if (held) begin
				step_q <= step_q;
			end else if (taken) begin
				step_q <= uw.target;
			end else begin
				step_q <= step_q + pda_pkg::STEP_W'(1);
			end
			if (go && uw.act == pda_pkg::ACT_LOAD) begin
				second_q <= 1'b0;
			end else if (go && uw.act == pda_pkg::ACT_FIRST && partner) begin
				second_q <= 1'b1;
			end
			// A new result wins over the transfer of the one before it.
			if (go && uw.act == pda_pkg::ACT_EMIT) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	// Datapath registers, driven by the action field of the control word.
	always_ff @(posedge clk) begin
		if (go) begin
			case (uw.act)
				pda_pkg::ACT_LOAD: begin
					n_q    <= number & IN_MASK;
					oper_q <= OW'(number & IN_MASK);
					amic_q <= 1'b0;
				end
				pda_pkg::ACT_INIT: begin
					trial_q <= TW'(1);
					sq_q    <= QW'(1);
					cnt_q   <= '0;
					sum_q   <= '0;
				end
				pda_pkg::ACT_ACCUM: begin
					if (div_rem == '0) begin
						if (div_quo != OW'(trial_q)) begin
							cnt_q <= cnt_q + CW'(2);
							sum_q <= sum_q + SW'(trial_q) + SW'(div_quo);
						end else begin
							cnt_q <= cnt_q + CW'(1);
							sum_q <= sum_q + SW'(trial_q);
						end
					end
					trial_q <= trial_q + TW'(1);
					sq_q    <= sq_q + QW'(trial_q) + QW'(trial_q) + QW'(1);
				end
				pda_pkg::ACT_FINISH: begin
					// Drop the operand itself; zero has no candidates at all.
					if (oper_q == '0) begin
						cnt_q <= '0;
						sum_q <= '0;
					end else begin
						cnt_q <= cnt_q - CW'(1);
						sum_q <= sum_q - SW'(oper_q);
					end
				end
				pda_pkg::ACT_FIRST: begin
					fp_cnt_q  <= cnt_q;
					fp_sum_q  <= sum_q;
					perfect_q <= (n_q != '0) && (sum_q == SW'(n_q));
					if (partner) begin
						oper_q <= sum_q[OW-1:0];
					end
				end
				pda_pkg::ACT_CHECK: begin
					amic_q <= (sum_q == SW'(n_q));
				end
				pda_pkg::ACT_EMIT: begin
					divisor_count       <= fp_cnt_q;
					divisor_sum         <= fp_sum_q;
					is_perfect          <= perfect_q;
					is_amicable_smaller <= amic_q;
				end
				default: begin
				end
			endcase
		end
	end

	// The number is only taken while the divider is idle.
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		num_ready |-> !div_busy)
		else $error("number taken while divider busy");

	// Starting a division makes the divider busy in the next cycle.
	a_div_starts: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> div_busy)
		else $error("divider did not start");

	// The running square tracks the candidate at every test.
	a_square_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == pda_pkg::STEP_TEST) |->
			((QW + 1)'(sq_q) == (QW + 1)'(34'(trial_q) * 34'(trial_q))))
		else $error("candidate square out of step");

	// A perfect number can never be the smaller member of an amicable pair.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(is_perfect && is_amicable_smaller))
		else $error("perfect and amicable both set");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the proper divisor analyzer: queue-fed driver, monitor, scoreboard.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Test plan
	//   The number channel is fed from a queue of pending values. A predictor computes
	//   count, sum and both flags for every accepted number. A monitor compares each
	//   result transfer, field by field, with the oldest prediction.
	//   Phases:
	//     - directed values: zero, one, a prime, the perfect numbers, amicable pairs,
	//       squares (the root divisor counts once), an odd abundant number and
	//       the all-ones maximum
	//     - partner limit moved across the amicable boundary: exactly the partner,
	//       one below it, zero and one
	//     - random values at the full limit, then at a random limit
	//     - a stretch with no idling on either side
	//     - back-pressure: the receiver holds off for a long stretch while the
	//       sender keeps offering values, so the held result and the next one
	//       fill the block and its input stalls
	//   The cost of one value grows with its square root (and with that of its sum
	//   when the partner check runs), so random values stay small. Only the
	//   directed maximum and a few mid-sized values are expensive.

	localparam int          HALF_PERIOD = 10;
	localparam int          RESET_CYCLES = 9;
	localparam int          IDLE_PCT = 36;
	localparam int          HOLD_CYCLES = 20000;
	localparam int          DRAIN_CYCLES = 100;
	localparam int          REPORT_MAX = 10;
	// One all-ones value runs with no transfer at all.
	localparam int unsigned WATCHDOG_CYCLES = 25_000_000;

	localparam int NW = pda_pkg::NUMBER_W;
	localparam int CW = pda_pkg::COUNT_W;
	localparam int SW = pda_pkg::SUM_W;

	localparam longint unsigned COUNT_MAX = (64'd1 << CW) - 1;
	localparam longint unsigned SUM_MAX   = (64'd1 << SW) - 1;
	localparam logic [NW-1:0]   LIMIT_FULL = '1;

	typedef struct packed {
		logic [CW-1:0] count;
		logic [SW-1:0] sum;
		logic          perfect;
		logic          amicable;
	} analysis_t;

	// DUT inputs carry known values from time zero.
	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          num_valid = 1'b0;
	logic          num_ready;
	logic [NW-1:0] number = '0;
	logic          res_valid;
	logic          res_ready = 1'b0;
	logic [CW-1:0] divisor_count;
	logic [SW-1:0] divisor_sum;
	logic          is_perfect;
	logic          is_amicable_smaller;
	logic          partner_limit_we = 1'b0;
	logic [NW-1:0] partner_limit_wdata = '0;

	// Testbench control.
	logic                calm = 1'b0;        // no idling on either side
	logic                squeeze_go = 1'b0;  // request the long receiver hold-off
	logic                squeeze_done = 1'b0;
	int unsigned         stall_left = 0;
	int unsigned         quiet_cycles = 0;

	logic [NW-1:0]       pending_numbers[$];
	analysis_t           expected_analyses[$];
	longint unsigned     limit_model = LIMIT_FULL;
	int                  fault_cnt = 0;
	int                  result_idx = 0;

	// Values with known structure: perfect numbers, amicable pairs, an odd abundant, squares and one.
	logic [NW-1:0] notable[] = '{6, 28, 496, 8128, 220, 284, 1184, 1210, 2620, 2924,
		5020, 5564, 6232, 6368, 10744, 10856, 12285, 14595, 17296, 18416, 945, 36, 49, 1};

	always #(HALF_PERIOD) clk = ~clk;

	proper_divisor_analyzer u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.num_valid           (num_valid),
		.num_ready           (num_ready),
		.number              (number),
		.res_valid           (res_valid),
		.res_ready           (res_ready),
		.divisor_count       (divisor_count),
		.divisor_sum         (divisor_sum),
		.is_perfect          (is_perfect),
		.is_amicable_smaller (is_amicable_smaller),
		.partner_limit_we    (partner_limit_we),
		.partner_limit_wdata (partner_limit_wdata)
	);

	// Exact count and sum of proper divisors by trial division up to the root.
	// A root divisor is counted once.
	function automatic void tally_divisors(input longint unsigned n,
		output longint unsigned cnt, output longint unsigned sum);
		longint unsigned i, q, c, s;
		c = 0;
		s = 0;
		cnt = 0;
		sum = 0;
		if (n != 0) begin
			for (i = 1; i * i <= n; i++) begin
				if (n % i == 0) begin
					q = n / i;
					if (q != i) begin
						c += 2;
						s += i + q;
					end else begin
						c += 1;
						s += i;
					end
				end
			end
			// Drop the number itself.
			cnt = c - 1;
			sum = s - n;
		end
	endfunction

	// Expected result of one number under the current partner limit. The instance
	// keeps the default width, so all 32 bits of the value take part.
	function automatic analysis_t analyze_number(input logic [NW-1:0] value);
		analysis_t       r;
		longint unsigned n, cnt, sum, pcnt, psum;
		n = value;
		r = '0;
		tally_divisors(n, cnt, sum);
		if (n != 0) begin
			r.perfect = (sum == n);
			// Partner pass only for a larger sum inside the limit.
			if (sum > n && sum <= limit_model) begin
				tally_divisors(sum, pcnt, psum);
				r.amicable = (psum == n);
			end
		end
		// Saturate; the flags above used the exact sum.
		r.count = (cnt > COUNT_MAX) ? COUNT_MAX[CW-1:0] : cnt[CW-1:0];
		r.sum   = (sum > SUM_MAX) ? SUM_MAX[SW-1:0] : sum[SW-1:0];
		return r;
	endfunction

	// Mostly small values, a share of notable ones, a few mid-sized.
	function automatic logic [NW-1:0] pick_number();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 22)
			return notable[$urandom_range(0, notable.size() - 1)];
		else if (sel < 94)
			return $urandom_range(1, 4095);
		else
			return $urandom_range(4096, 1 << 20);
	endfunction

	// Driver: predict on every number transfer, then load the next pending
	// value or idle. A value that waits for ready is held as it is.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_valid <= 1'b0;
			number    <= '0;
		end else begin
			if (num_valid && num_ready)
				expected_analyses.push_back(analyze_number(number));
			if (!num_valid || num_ready) begin
				if (pending_numbers.size() != 0 &&
				    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					number    <= pending_numbers.pop_front();
					num_valid <= 1'b1;
				end else begin
					num_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random ready, and a single long hold-off, counted here, on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready    <= 1'b0;
			stall_left   <= 0;
			squeeze_done <= 1'b0;
		end else begin
			if (squeeze_go && !squeeze_done) begin
				stall_left   <= HOLD_CYCLES;
				squeeze_done <= 1'b1;
				res_ready    <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				res_ready  <= 1'b0;
			end else begin
				res_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Monitor: every result transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		analysis_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_analyses.size() == 0) begin
				fault_cnt++;
				if (fault_cnt <= REPORT_MAX)
					$display("result %0d: unexpected, ", result_idx,
						"count=%0d sum=%0d ", divisor_count, divisor_sum,
						"perfect=%0b amicable=%0b", is_perfect, is_amicable_smaller);
			end else begin
				want = expected_analyses.pop_front();
				if (divisor_count !== want.count || divisor_sum !== want.sum ||
				    is_perfect !== want.perfect || is_amicable_smaller !== want.amicable) begin
					fault_cnt++;
					if (fault_cnt <= REPORT_MAX)
						$display("result %0d: expected count=%0d sum=%0d ",
							result_idx, want.count, want.sum,
							"perfect=%0b amicable=%0b, ", want.perfect, want.amicable,
							"got count=%0d sum=%0d ", divisor_count, divisor_sum,
							"perfect=%0b amicable=%0b", is_perfect, is_amicable_smaller);
				end
			end
			result_idx++;
		end
	end

	// Watchdog: end the run after too long without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (num_valid && num_ready) || (res_valid && res_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Write the partner limit while the block is idle and track it for prediction.
	task automatic write_limit(input logic [NW-1:0] value);
		@(posedge clk);
		partner_limit_we    <= 1'b1;
		partner_limit_wdata <= value;
		@(posedge clk);
		partner_limit_we <= 1'b0;
		limit_model = value;
		@(negedge clk);
	endtask

	// Hold until every pending value went in and every result came back.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_numbers.size() != 0 || num_valid || expected_analyses.size() != 0);
	endtask

	task automatic queue_random(input int count);
		repeat (count) pending_numbers.push_back(pick_number());
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Full limit, written explicitly although it is the reset value.
		write_limit(LIMIT_FULL);
		// Zero and one yield nothing. 2 is prime; 36 and 49 have a root divisor;
		// 12 and 945 are abundant but not amicable; the all-ones value sets every bit.
		pending_numbers = '{0, 1, 2, 6, 12, 28, 36, 49, 220, 284, 496, 1184, 1210,
			945, 8128, LIMIT_FULL};
		drain();

		// Limit exactly at the partner of 220: still amicable. 1184 falls outside.
		write_limit(284);
		pending_numbers = '{220, 1184};
		drain();
		// One below the partner: the pair is no longer reported.
		write_limit(283);
		pending_numbers.push_back(220);
		drain();
		// Zero limit: no partner can qualify.
		write_limit('0);
		pending_numbers = '{220, 6};
		drain();
		write_limit(1);
		pending_numbers.push_back(12);
		drain();

		// Random values at the full limit, then under a random limit.
		write_limit(LIMIT_FULL);
		queue_random(20);
		drain();
		write_limit($urandom_range(300, 20000));
		queue_random(15);
		drain();

		// Back to back, with no idling on either side.
		write_limit(LIMIT_FULL);
		@(posedge clk);
		calm <= 1'b1;
		queue_random(20);
		drain();
		@(posedge clk);
		calm <= 1'b0;

		// Long receiver hold-off with cheap values behind it, then random traffic.
		@(posedge clk);
		squeeze_go <= 1'b1;
		repeat (8) pending_numbers.push_back($urandom_range(1, 500));
		queue_random(17);
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[sim.f]
src/pda_pkg.sv
src/pda_div.sv
src/proper_divisor_analyzer.sv
tb/tb_top.sv
